### hdl/wstd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wstd_pkg
// Shared types and codes for the work stealing task dispatcher.
// ----------------------------------------------------------------------------
package wstd_pkg;

    // Dispatcher geometry
    localparam int WORKERS     = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;

    // Request kinds
    localparam logic [1:0] KIND_ENQ   = 2'd0;
    localparam logic [1:0] KIND_TAKE  = 2'd1;
    localparam logic [1:0] KIND_BIND  = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_ENQ     = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_TAKEN   = 3'd2;
    localparam logic [2:0] ST_NONE    = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture request, start scan setup
        logic scan;      // examine current memory read, advance pointer
        logic shift;     // move one entry down during removal
        logic finish;    // apply update and load result register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_take;   // request is a take with a valid worker
        logic hit;       // scan found an eligible entry
        logic scan_end;  // hit found or no more entries to scan
        logic shift_end; // removal compaction complete
    } t_sts;

endpackage
`default_nettype wire

### hdl/wstd_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wstd_dpath
// Queue memory, counters, thread bindings, scan pointer and result register.
// ----------------------------------------------------------------------------
module wstd_dpath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wstd_pkg::t_cmd      i_cmd,
    output wstd_pkg::t_sts      o_sts,
    input  wire  [1:0]          i_kind,
    input  wire  [15:0]         i_task_id,
    input  wire                 i_pinned,
    input  wire  [15:0]         i_pin_thread,
    input  wire                 i_from_worker_valid,
    input  wire  [1:0]          i_worker,
    input  wire  [15:0]         i_thread_id,
    output logic [2:0]          o_status,
    output logic                o_was_empty,
    output logic [15:0]         o_out_task_id,
    output logic                o_out_pinned,
    output logic [15:0]         o_out_pin_thread,
    output logic [1:0]          o_source_worker,
    output logic                o_stolen,
    output logic                o_pending
);

    localparam int WORKERS     = wstd_pkg::WORKERS;
    localparam int QUEUE_DEPTH = wstd_pkg::QUEUE_DEPTH;
    localparam int ID_BITS     = wstd_pkg::ID_BITS;

    localparam int WB  = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int PB  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CB  = $clog2(QUEUE_DEPTH + 1);
    localparam int EB  = 2 * ID_BITS + 1;
    localparam int MD  = WORKERS * QUEUE_DEPTH;

    // Queue storage: {pinned, thread, task}
    logic [EB-1:0] r_mem [MD];
    logic [EB-1:0] r_rd;

    logic [CB-1:0]      r_cnt   [WORKERS];
    logic               r_bound [WORKERS];
    logic [ID_BITS-1:0] r_thr   [WORKERS];
    logic [WB-1:0]      r_rr;

    // Captured request
    logic [1:0]         r_kind;
    logic [ID_BITS-1:0] r_task, r_pthr, r_tin;
    logic               r_pin, r_from;
    logic [1:0]         r_wk;

    // Scan state
    logic [WB-1:0] r_qw;       // queue being scanned
    logic [WB-1:0] r_off;      // ring offset of that queue
    logic [CB-1:0] r_pos;      // position being read
    logic          r_hit;
    logic [WB-1:0] r_hw;
    logic [PB-1:0] r_hp;
    logic [EB-1:0] r_he;
    logic [CB-1:0] r_sp;       // shift pointer
    logic          r_rdv;      // memory read data is for r_pos

    // Result register
    logic [2:0]  r_status, n_status;
    logic        r_was_empty, n_was_empty;
    logic [15:0] r_out_task_id, n_out_task_id;
    logic        r_out_pinned, n_out_pinned;
    logic [15:0] r_out_pin_thread, n_out_pin_thread;
    logic [1:0]  r_source_worker, n_source_worker;
    logic        r_stolen, n_stolen;
    logic        r_pending;

    // Take helpers
    logic          wk_ok;
    logic [WB-1:0] wkw;
    always_comb begin
        wk_ok = ({30'd0, r_wk} < WORKERS);
        wkw   = WB'(r_wk);
    end

    // Eligibility of the current read
    logic elig;
    always_comb begin
        elig = !r_rd[EB-1] ||
               (r_bound[wkw] && r_rd[2*ID_BITS-1:ID_BITS] == r_thr[wkw]);
    end

    // Scan-position bookkeeping: own queue goes forward, others backward
    logic          in_range;
    logic [CB-1:0] nxt_pos;
    logic          last_q;
    always_comb begin
        in_range = (r_off == '0) ? (r_pos < r_cnt[r_qw]) : (r_pos != '0);
        nxt_pos  = (r_off == '0) ? r_pos + 1'b1 : r_pos - 1'b1;
        last_q   = ({{(32-WB){1'b0}}, r_off} == WORKERS - 1);
    end

    // Memory read address
    logic [PB-1:0] rd_p;
    always_comb begin
        if (r_off == '0) rd_p = r_pos[PB-1:0];
        else             rd_p = PB'(r_pos - 1'b1);
    end

    // Enqueue target
    logic [WB-1:0] tgt;
    logic          use_rr;
    always_comb begin
        tgt    = r_rr;
        use_rr = 1'b1;
        if (r_pin) begin
            for (int w = WORKERS - 1; w >= 0; w--) begin
                if (r_bound[w] && r_thr[w] == r_pthr) begin
                    tgt    = WB'(w);
                    use_rr = 1'b0;
                end
            end
        end else if (r_from && wk_ok) begin
            tgt    = wkw;
            use_rr = 1'b0;
        end
    end

    logic any_after;
    logic [CB-1:0] tcnt;
    always_comb begin
        tcnt = r_cnt[tgt];
        any_after = 1'b0;
        for (int w = 0; w < WORKERS; w++) begin
            if (r_cnt[w] != '0) any_after = 1'b1;
        end
        if (r_kind == wstd_pkg::KIND_ENQ && tcnt < QUEUE_DEPTH) any_after = 1'b1;
        if (r_kind == wstd_pkg::KIND_TAKE && r_hit) begin
            any_after = 1'b0;
            for (int w = 0; w < WORKERS; w++) begin
                if (WB'(w) == r_hw) begin
                    if (r_cnt[w] > 1) any_after = 1'b1;
                end else if (r_cnt[w] != '0) begin
                    any_after = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_sts.is_take   = (r_kind == wstd_pkg::KIND_TAKE) && wk_ok;
        o_sts.hit       = r_hit;
        o_sts.scan_end  = r_hit || (!in_range && last_q);
        o_sts.shift_end = (r_sp + 1'b1 >= r_cnt[r_hw]);
    end

    // Memory write/read
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_kind == wstd_pkg::KIND_ENQ && tcnt < QUEUE_DEPTH) begin
            r_mem[{tgt, tcnt[PB-1:0]}] <= {r_pin, (r_pin ? r_pthr : '0), r_task};
        end
        if (i_cmd.shift) begin
            r_mem[{r_hw, r_sp[PB-1:0]}] <= r_rd;
            r_rd <= r_mem[{r_hw, PB'(r_sp + 2'd2)}];
        end else if (i_cmd.scan && r_hit) begin
            r_rd <= r_mem[{r_hw, PB'(r_hp + 1'b1)}];
        end else begin
            r_rd <= r_mem[{r_qw, rd_p}];
        end
    end

    // Control and scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WORKERS; w++) begin
                r_cnt[w]   <= '0;
                r_bound[w] <= 1'b0;
            end
            r_rr  <= '0;
            r_hit <= 1'b0;
            r_rdv <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_kind <= i_kind;
                r_task <= i_task_id;
                r_pin  <= i_pinned;
                r_pthr <= i_pin_thread;
                r_from <= i_from_worker_valid;
                r_wk   <= i_worker;
                r_tin  <= i_thread_id;
                r_qw   <= WB'(i_worker);
                r_off  <= '0;
                r_pos  <= '0;
                r_hit  <= 1'b0;
                r_rdv  <= 1'b0;
            end
            if (i_cmd.scan && !r_hit) begin
                if (!r_rdv) begin
                    r_rdv <= 1'b1;
                end else if (in_range && elig) begin
                    r_hit <= 1'b1;
                    r_hw  <= r_qw;
                    r_hp  <= rd_p;
                    r_he  <= r_rd;
                    r_sp  <= CB'(rd_p);
                end else if (in_range) begin
                    r_pos <= nxt_pos;
                    r_rdv <= 1'b0;
                end else if (!last_q) begin
                    r_off <= r_off + 1'b1;
                    r_qw  <= (({1'b0, r_qw} + 1'b1) == (WB+1)'(WORKERS)) ? '0 : r_qw + 1'b1;
                    r_pos <= r_cnt[(({1'b0, r_qw} + 1'b1) == (WB+1)'(WORKERS)) ?
                                   WB'(0) : WB'(r_qw + 1'b1)];
                    r_rdv <= 1'b0;
                end
            end
            if (i_cmd.shift) r_sp <= r_sp + 1'b1;
            if (i_cmd.finish) begin
                case (r_kind)
                    wstd_pkg::KIND_ENQ: begin
                        if (use_rr) begin
                            r_rr <= (({1'b0, r_rr} + 1'b1) == (WB+1)'(WORKERS)) ?
                                    '0 : r_rr + 1'b1;
                        end
                        if (tcnt < QUEUE_DEPTH) r_cnt[tgt] <= tcnt + 1'b1;
                    end
                    wstd_pkg::KIND_TAKE: begin
                        if (r_hit) r_cnt[r_hw] <= r_cnt[r_hw] - 1'b1;
                    end
                    wstd_pkg::KIND_BIND: begin
                        if (wk_ok) begin
                            r_bound[wkw] <= 1'b1;
                            r_thr[wkw]   <= r_tin;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Form the result of the finished request
    always_comb begin
        n_status         = wstd_pkg::ST_DONE;
        n_was_empty      = 1'b0;
        n_out_task_id    = '0;
        n_out_pinned     = 1'b0;
        n_out_pin_thread = '0;
        n_source_worker  = '0;
        n_stolen         = 1'b0;
        case (r_kind)
            wstd_pkg::KIND_ENQ: begin
                n_source_worker = 2'(tgt);
                if (tcnt < QUEUE_DEPTH) begin
                    n_status    = wstd_pkg::ST_ENQ;
                    n_was_empty = (tcnt == '0);
                end else begin
                    n_status    = wstd_pkg::ST_FULL;
                end
            end
            wstd_pkg::KIND_TAKE: begin
                if (r_hit) begin
                    n_status         = wstd_pkg::ST_TAKEN;
                    n_out_task_id    = 16'(r_he[ID_BITS-1:0]);
                    n_out_pinned     = r_he[EB-1];
                    n_out_pin_thread = 16'(r_he[2*ID_BITS-1:ID_BITS]);
                    n_source_worker  = 2'(r_hw);
                    n_stolen         = (r_hw != wkw);
                end else begin
                    n_status = wstd_pkg::ST_NONE;
                end
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status         <= n_status;
            r_was_empty      <= n_was_empty;
            r_out_task_id    <= n_out_task_id;
            r_out_pinned     <= n_out_pinned;
            r_out_pin_thread <= n_out_pin_thread;
            r_source_worker  <= n_source_worker;
            r_stolen         <= n_stolen;
            r_pending        <= any_after;
        end
    end

    assign o_status         = r_status;
    assign o_was_empty      = r_was_empty;
    assign o_out_task_id    = r_out_task_id;
    assign o_out_pinned     = r_out_pinned;
    assign o_out_pin_thread = r_out_pin_thread;
    assign o_source_worker  = r_source_worker;
    assign o_stolen         = r_stolen;
    assign o_pending        = r_pending;

endmodule
`default_nettype wire

### hdl/wstd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wstd_ctrl
// Sequencer for request capture, queue scan, removal and result handoff.
// ----------------------------------------------------------------------------
module wstd_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  wire             i_stall,
    output wstd_pkg::t_cmd  o_cmd,
    input  wstd_pkg::t_sts  i_sts
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_FIN   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_ov, n_ov;

    always_comb begin
        n_state = r_state;
        n_ov    = r_ov;
        o_cmd   = '0;
        o_stall = 1'b1;
        if (r_ov && !i_stall) n_ov = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_sts.is_take) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_sts.scan_end) begin
                        n_state = i_sts.hit ? S_SHIFT : S_FIN;
                    end
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_end) n_state = S_FIN;
                else o_cmd.shift = 1'b1;
            end
            S_FIN: begin
                if (!r_ov || !i_stall) begin
                    o_cmd.finish = 1'b1;
                    n_ov         = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

endmodule
`default_nettype wire

### hdl/work_stealing_task_dispatcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// work_stealing_task_dispatcher
// Per-worker task queues with pinned placement and work stealing.
// ----------------------------------------------------------------------------
// One request at a time. Enqueue, bind and pending query pass through capture,
// decode and finish; the result is registered at finish. A take scans its own
// queue forward, then the other queues backward, one entry at a time through
// the single read port of the queue memory, then compacts the hit queue one
// entry per cycle. The result sits in an output register so the next request
// is taken while it waits; a new result is held back until the previous one
// has transferred.
module work_stealing_task_dispatcher (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_kind,
    input  wire  [15:0] i_task_id,
    input  wire         i_pinned,
    input  wire  [15:0] i_pin_thread,
    input  wire         i_from_worker_valid,
    input  wire  [1:0]  i_worker,
    input  wire  [15:0] i_thread_id,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_status,
    output logic        o_was_empty,
    output logic [15:0] o_out_task_id,
    output logic        o_out_pinned,
    output logic [15:0] o_out_pin_thread,
    output logic [1:0]  o_source_worker,
    output logic        o_stolen,
    output logic        o_pending
);

    wstd_pkg::t_cmd cmd;
    wstd_pkg::t_sts sts;

    wstd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    wstd_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_kind              (i_kind),
        .i_task_id           (i_task_id),
        .i_pinned            (i_pinned),
        .i_pin_thread        (i_pin_thread),
        .i_from_worker_valid (i_from_worker_valid),
        .i_worker            (i_worker),
        .i_thread_id         (i_thread_id),
        .o_status            (o_status),
        .o_was_empty         (o_was_empty),
        .o_out_task_id       (o_out_task_id),
        .o_out_pinned        (o_out_pinned),
        .o_out_pin_thread    (o_out_pin_thread),
        .o_source_worker     (o_source_worker),
        .o_stolen            (o_stolen),
        .o_pending           (o_pending)
    );

endmodule
`default_nettype wire
